>>> rtl/core/escaped_frame_tx_ring_macros.svh
// Assertion macros for the escaped frame transmit ring.
// Included by the top level; needs no other file.
`ifndef ESCAPED_FRAME_TX_RING_MACROS_SVH
`define ESCAPED_FRAME_TX_RING_MACROS_SVH
`ifndef NO_ASSERTIONS
`define EFTR_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
`define EFTR_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define EFTR_ASSERT_IMP(name, clk, rst, ante, cons)
`define EFTR_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/eftr_pkg.sv
// Shared constants, codes and controller/datapath interface types
// for the escaped frame transmit ring. No dependencies.
package eftr_pkg;

  localparam int BUF_DEPTH = 64;
  localparam int PTR_W     = $clog2(BUF_DEPTH);
  localparam int LEN_W     = $clog2(BUF_DEPTH + 1);

  localparam logic [7:0] HEAD_BYTE = 8'hFD;
  localparam logic [7:0] ESC_BYTE  = 8'hFE;
  localparam logic [7:0] TAIL_BYTE = 8'hF8;
  localparam logic [7:0] ESC_HEAD  = 8'h7D;
  localparam logic [7:0] ESC_ESC   = 8'h7E;
  localparam logic [7:0] ESC_TAIL  = 8'h78;

  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_LAST = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  localparam logic [1:0] FS_NONE   = 2'd0;
  localparam logic [1:0] FS_QUEUED = 2'd1;
  localparam logic [1:0] FS_DROP   = 2'd2;
  localparam logic [1:0] FS_CUT    = 2'd3;

  typedef enum logic [1:0] {
    SRC_HEAD,
    SRC_STAGE,
    SRC_CSUM,
    SRC_TAIL
  } put_src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ESC2,
    ST_CHECK,
    ST_HEAD,
    ST_SRD,
    ST_SWR,
    ST_CSUM,
    ST_TAIL,
    ST_TICK
  } state_t;

  typedef struct packed {
    logic       stage_first;
    logic       stage_second;
    logic       stage_clear;
    logic       idx_init;
    logic       idx_inc;
    logic       ring_put;
    put_src_t   put_src;
    logic       ring_rd;
    logic       err_inc;
    logic       load_out;
    logic       tx_hit;
    logic [1:0] out_status;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic esc_hit;
    logic too_long;
    logic ring_full;
    logic ring_empty;
    logic has_payload;
    logic copy_more;
  } sts_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(BUF_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/eftr_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module eftr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/eftr_ctrl.sv
// Sequencing state machine: staging, frame commit copy and ring pops.
// Depends on eftr_pkg.
module eftr_ctrl import eftr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] mode,
  output logic       in_stall,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t state, state_next;
  logic   last_q;
  logic   accept;

  assign in_stall = (state != ST_IDLE) || sts.out_busy;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      last_q <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        last_q <= (mode == MODE_LAST);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (mode == MODE_BYTE || mode == MODE_LAST) begin
            if (sts.esc_hit) begin
              state_next = ST_ESC2;
            end else if (mode == MODE_LAST) begin
              state_next = ST_CHECK;
            end
          end else if (mode == MODE_TICK && !sts.ring_empty) begin
            state_next = ST_TICK;
          end
        end
      end
      ST_ESC2:  state_next = last_q ? ST_CHECK : ST_IDLE;
      ST_CHECK: state_next = sts.too_long ? ST_IDLE : ST_HEAD;
      ST_HEAD: begin
        if (sts.ring_full) begin
          state_next = ST_IDLE;
        end else begin
          state_next = sts.has_payload ? ST_SRD : ST_CSUM;
        end
      end
      ST_SRD: state_next = ST_SWR;
      ST_SWR: begin
        if (sts.ring_full) begin
          state_next = ST_IDLE;
        end else begin
          state_next = sts.copy_more ? ST_SRD : ST_CSUM;
        end
      end
      ST_CSUM: state_next = sts.ring_full ? ST_IDLE : ST_TAIL;
      ST_TAIL: state_next = ST_IDLE;
      ST_TICK: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.put_src = SRC_HEAD;
    cmd.out_status = FS_NONE;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (mode == MODE_BYTE || mode == MODE_LAST) begin
            cmd.stage_first = 1'b1;
            cmd.load_out = !sts.esc_hit && (mode == MODE_BYTE);
          end else if (mode == MODE_TICK && !sts.ring_empty) begin
            cmd.ring_rd = 1'b1;
          end else begin
            cmd.load_out = 1'b1;
          end
        end
      end
      ST_ESC2: begin
        cmd.stage_second = 1'b1;
        cmd.load_out = !last_q;
      end
      ST_CHECK: begin
        if (sts.too_long) begin
          cmd.err_inc = 1'b1;
          cmd.load_out = 1'b1;
          cmd.out_status = FS_DROP;
          cmd.stage_clear = 1'b1;
        end
      end
      ST_HEAD, ST_SWR, ST_CSUM, ST_TAIL: begin
        if (sts.ring_full) begin
          cmd.err_inc = 1'b1;
          cmd.load_out = 1'b1;
          cmd.out_status = FS_CUT;
          cmd.stage_clear = 1'b1;
        end else begin
          cmd.ring_put = 1'b1;
          case (state)
            ST_HEAD: begin
              cmd.put_src = SRC_HEAD;
              cmd.idx_init = 1'b1;
            end
            ST_SWR: begin
              cmd.put_src = SRC_STAGE;
              cmd.idx_inc = 1'b1;
            end
            ST_CSUM: cmd.put_src = SRC_CSUM;
            default: begin
              cmd.put_src = SRC_TAIL;
              cmd.load_out = 1'b1;
              cmd.out_status = FS_QUEUED;
              cmd.stage_clear = 1'b1;
            end
          endcase
        end
      end
      ST_TICK: begin
        cmd.load_out = 1'b1;
        cmd.tx_hit = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/eftr_dp.sv
// Datapath: staging store, checksum, transmit ring, error count, result register.
// Depends on eftr_pkg and eftr_ram.
module eftr_dp import eftr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic [1:0]  frame_status,
  output logic [15:0] error_count
);

  logic [LEN_W-1:0] stage_len;
  logic [LEN_W-1:0] idx;
  logic [7:0]       csum;
  logic [7:0]       esc_code;
  logic [PTR_W-1:0] rp;
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] wp_inc;
  logic [15:0]      errors;
  logic [15:0]      errors_next;

  logic             esc_hit;
  logic [7:0]       esc_sel;
  logic             stage_we;
  logic [7:0]       stage_wdata;
  logic [7:0]       stage_rdata;
  logic [7:0]       ring_wdata;
  logic [7:0]       ring_rdata;
  logic [LEN_W:0]   len_plus2;
  logic [LEN_W:0]   idx_plus1;

  always_comb begin
    esc_hit = 1'b1;
    esc_sel = ESC_HEAD;
    case (data_byte)
      HEAD_BYTE: esc_sel = ESC_HEAD;
      ESC_BYTE:  esc_sel = ESC_ESC;
      TAIL_BYTE: esc_sel = ESC_TAIL;
      default:   esc_hit = 1'b0;
    endcase
  end

  assign stage_we    = (cmd.stage_first || cmd.stage_second) &&
                       (stage_len < LEN_W'(BUF_DEPTH));
  assign stage_wdata = cmd.stage_second ? esc_code : (esc_hit ? ESC_BYTE : data_byte);

  eftr_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_stage (
    .clk   (clk),
    .we    (stage_we),
    .waddr (stage_len[PTR_W-1:0]),
    .wdata (stage_wdata),
    .raddr (idx[PTR_W-1:0]),
    .rdata (stage_rdata)
  );

  assign wp_inc = ptr_inc(wp);

  always_comb begin
    case (cmd.put_src)
      SRC_HEAD:  ring_wdata = HEAD_BYTE;
      SRC_STAGE: ring_wdata = stage_rdata;
      SRC_CSUM:  ring_wdata = csum;
      default:   ring_wdata = TAIL_BYTE;
    endcase
  end

  eftr_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_ring (
    .clk   (clk),
    .we    (cmd.ring_put),
    .waddr (wp_inc),
    .wdata (ring_wdata),
    .raddr (ptr_inc(rp)),
    .rdata (ring_rdata)
  );

  assign len_plus2   = {1'b0, stage_len} + (LEN_W + 1)'(2);
  assign idx_plus1   = {1'b0, idx} + 1'b1;
  assign errors_next = errors + {15'd0, cmd.err_inc};

  assign sts.out_busy    = out_valid && out_stall;
  assign sts.esc_hit     = esc_hit;
  assign sts.too_long    = len_plus2 >= (LEN_W + 1)'(BUF_DEPTH);
  assign sts.ring_full   = (wp_inc == rp);
  assign sts.ring_empty  = (rp == wp);
  assign sts.has_payload = stage_len > LEN_W'(1);
  assign sts.copy_more   = idx_plus1 < {1'b0, stage_len};

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_len <= LEN_W'(1);
      csum      <= '0;
      rp        <= '0;
      wp        <= '0;
      errors    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.stage_clear) begin
        stage_len <= LEN_W'(1);
        csum      <= '0;
      end else begin
        if (stage_we) begin
          stage_len <= stage_len + 1'b1;
        end
        if (cmd.stage_first) begin
          csum <= csum + data_byte;
        end
      end
      if (cmd.ring_put) begin
        wp <= wp_inc;
      end
      if (cmd.ring_rd) begin
        rp <= ptr_inc(rp);
      end
      errors <= errors_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stage_first) begin
      esc_code <= esc_sel;
    end
    if (cmd.idx_init) begin
      idx <= LEN_W'(1);
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
    if (cmd.load_out) begin
      tx_valid     <= cmd.tx_hit;
      tx_byte      <= cmd.tx_hit ? ring_rdata : 8'd0;
      frame_status <= cmd.out_status;
      error_count  <= errors_next;
    end
  end

endmodule

>>> rtl/core/escaped_frame_tx_ring.sv
// Escaped frame transmit ring, top level: controller plus datapath.
// Depends on eftr_pkg, eftr_ctrl, eftr_dp and escaped_frame_tx_ring_macros.svh.
//
// Every item gives one result. A plain payload byte is taken in ST_IDLE. An
// escaped one also passes through ST_ESC2, because the staging RAM has a
// single write port. A last byte adds the commit: a length check, the header,
// for each staged byte after the header slot a registered staging RAM read
// (ST_SRD) then a ring write (ST_SWR), checksum and tail. When the last byte
// is escaped, ST_ESC2 comes before the check. A dropped frame ends after the
// check. A cut frame ends at the write that finds the ring full. A transmit
// tick reads the ring through ST_TICK (registered read) when it holds data,
// else its result comes from ST_IDLE. Stores need no clearing after reset.
`include "escaped_frame_tx_ring_macros.svh"
module escaped_frame_tx_ring import eftr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic [1:0]  frame_status,
  output logic [15:0] error_count
);

  cmd_t cmd;
  sts_t sts;

  eftr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  eftr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .data_byte    (data_byte),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .tx_valid     (tx_valid),
    .tx_byte      (tx_byte),
    .frame_status (frame_status),
    .error_count  (error_count)
  );

  `EFTR_ASSERT_IMP(a_put_not_full, clk, rst, cmd.ring_put, !sts.ring_full)
  `EFTR_ASSERT_IMP(a_load_free, clk, rst, cmd.load_out, !sts.out_busy)
  `EFTR_ASSERT_NXT(a_pop_result, clk, rst, cmd.ring_rd, cmd.load_out && cmd.tx_hit)
  `EFTR_ASSERT_IMP(a_tx_no_frame, clk, rst, out_valid && tx_valid, frame_status == FS_NONE)

endmodule

>>> tb/tb.sv
// Testbench for escaped_frame_tx_ring: byte-stuffed frames with checksum into a transmit ring.
// Self-checking: an internal framer/ring predictor is compared with every result transfer.
// Depends on eftr_pkg and the escaped_frame_tx_ring RTL only.
`timescale 1ns / 1ps

module tb;
  import eftr_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [1:0]  status;
    logic [15:0] errs;
  } tx_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = MODE_BYTE;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic [1:0]  frame_status;
  logic [15:0] error_count;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatch_cnt = 0;
  tx_result_t expected_q[$];

  // predictor state
  logic [7:0]       stage_mem [BUF_DEPTH];
  int unsigned      stage_len = 1;
  logic [7:0]       csum = 8'h00;
  logic [7:0]       ring_mem [BUF_DEPTH];
  logic [PTR_W-1:0] rd_ptr = '0;
  logic [PTR_W-1:0] wr_ptr = '0;
  logic [15:0]      err_cnt = 16'h0000;

  escaped_frame_tx_ring uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .tx_valid     (tx_valid),
    .tx_byte      (tx_byte),
    .frame_status (frame_status),
    .error_count  (error_count)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic void stage_push(input logic [7:0] b);
    if (stage_len < BUF_DEPTH) begin
      stage_mem[stage_len] = b;
      stage_len++;
    end
  endfunction

  function automatic bit ring_push(input logic [7:0] b);
    logic [PTR_W-1:0] nxt;
    nxt = PTR_W'((int'(wr_ptr) + 1) % BUF_DEPTH);
    if (nxt == rd_ptr) begin
      return 1'b0;
    end
    wr_ptr = nxt;
    ring_mem[wr_ptr] = b;
    return 1'b1;
  endfunction

  function automatic void err_bump();
    err_cnt++;
  endfunction

  function automatic logic [1:0] frame_commit();
    logic [1:0] st;
    bit         ok;
    st = FS_QUEUED;
    if (stage_len + 2 >= BUF_DEPTH) begin
      err_bump();
      st = FS_DROP;
    end else begin
      ok = ring_push(HEAD_BYTE);
      for (int i = 1; ok && i < stage_len; i++) begin
        ok = ring_push(stage_mem[i]);
      end
      if (ok) begin
        ok = ring_push(csum);
      end
      if (ok) begin
        ok = ring_push(TAIL_BYTE);
      end
      if (!ok) begin
        err_bump();
        st = FS_CUT;
      end
    end
    stage_len = 1;
    csum = 8'h00;
    return st;
  endfunction

  function automatic tx_result_t framer_predict(input logic [1:0] m, input logic [7:0] b);
    tx_result_t r;
    r = '0;
    if (m == MODE_BYTE || m == MODE_LAST) begin
      csum = csum + b;
      case (b)
        HEAD_BYTE: begin
          stage_push(ESC_BYTE);
          stage_push(ESC_HEAD);
        end
        ESC_BYTE: begin
          stage_push(ESC_BYTE);
          stage_push(ESC_ESC);
        end
        TAIL_BYTE: begin
          stage_push(ESC_BYTE);
          stage_push(ESC_TAIL);
        end
        default: begin
          stage_push(b);
        end
      endcase
      if (m == MODE_LAST) begin
        r.status = frame_commit();
      end
    end else if (m == MODE_TICK) begin
      if (rd_ptr != wr_ptr) begin
        rd_ptr = PTR_W'((int'(rd_ptr) + 1) % BUF_DEPTH);
        r.tx_byte = ring_mem[rd_ptr];
        r.tx_valid = 1'b1;
      end
    end
    r.errs = err_cnt;
    return r;
  endfunction

  function automatic logic [7:0] framer_rand_byte();
    case ($urandom_range(7))
      0: return HEAD_BYTE;
      1: return ESC_BYTE;
      2: return TAIL_BYTE;
      default: return 8'($urandom);
    endcase
  endfunction

  // one input transfer; prediction is made at the accepting edge
  task automatic send_item(input logic [1:0] m, input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(framer_predict(m, b));
  endtask

  task automatic ring_drain();
    while (rd_ptr != wr_ptr) send_item(MODE_TICK, 8'($urandom));
  endtask

  always @(posedge clk) begin : result_check
    tx_result_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = {tx_valid, tx_byte, frame_status, error_count};
      if (expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("%0t: unexpected result valid %0d byte %02h status %0d errors %0d",
                   $realtime, got.tx_valid, got.tx_byte, got.status, got.errs);
        end
      end else begin
        want = expected_q.pop_front();
        if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
            got.status !== want.status || got.errs !== want.errs) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: mismatch exp valid %0d byte %02h status %0d errors %0d",
                     $realtime, want.tx_valid, want.tx_byte, want.status, want.errs);
            $display("%0t:          got valid %0d byte %02h status %0d errors %0d",
                     $realtime, got.tx_valid, got.tx_byte, got.status, got.errs);
          end
        end
      end
    end
  end

  task automatic test_basic();
    send_item(MODE_TICK, 8'hFF);
    send_item(MODE_UNUSED, 8'hFF);
    send_item(MODE_UNUSED, 8'h00);
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_BYTE, HEAD_BYTE);
    send_item(MODE_BYTE, ESC_BYTE);
    send_item(MODE_BYTE, TAIL_BYTE);
    send_item(MODE_BYTE, 8'hFF);
    send_item(MODE_LAST, ESC_HEAD);
    repeat (13) send_item(MODE_TICK, 8'h00);
    // single header byte: checksum equals the header value and goes out raw
    send_item(MODE_LAST, HEAD_BYTE);
  endtask

  task automatic test_length_limits();
    ring_drain();
    // longest frame that fits: fills the ring exactly
    repeat (59) send_item(MODE_BYTE, 8'($urandom_range(247)));
    send_item(MODE_LAST, 8'($urandom_range(247)));
    send_item(MODE_LAST, 8'h01);
    repeat (BUF_DEPTH) send_item(MODE_TICK, 8'($urandom));
    // one byte longer: dropped
    repeat (60) send_item(MODE_BYTE, 8'($urandom_range(247)));
    send_item(MODE_LAST, 8'($urandom_range(247)));
    // staging saturates
    repeat (40) send_item(MODE_BYTE, ESC_BYTE);
    send_item(MODE_LAST, 8'hFF);
    send_item(MODE_TICK, 8'h00);
  endtask

  task automatic test_random(input int n_items);
    int sent, len, r;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 6) begin
        send_item(MODE_UNUSED, 8'($urandom));
      end else if (r < 50) begin
        len = $urandom_range(1, 12);
        repeat (len) send_item(MODE_TICK, 8'($urandom));
        sent += len;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 8);
        repeat (len - 1) send_item(MODE_BYTE, framer_rand_byte());
        send_item(MODE_LAST, framer_rand_byte());
        sent += len;
      end
    end
  endtask

  // ring held full so every further one-byte frame is cut
  task automatic test_ring_full();
    ring_drain();
    repeat (58) send_item(MODE_BYTE, 8'($urandom_range(247)));
    repeat (6) send_item(MODE_LAST, 8'($urandom));
    ring_drain();
    send_item(MODE_TICK, 8'h00);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic();
    test_length_limits();
    test_random(340);
    send_idle_pct = 76;
    test_random(340);
    send_idle_pct = 0;
    stall_pct = 76;
    test_random(340);
    send_idle_pct = 18;
    stall_pct = 18;
    test_random(340);
    send_idle_pct = 0;
    stall_pct = 0;
    test_ring_full();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (mismatch_cnt == 0 && expected_q.size() == 0) begin
      $display("escaped_frame_tx_ring test passed");
    end else begin
      $display("escaped_frame_tx_ring test failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("escaped_frame_tx_ring test failed");
    $finish;
  end

endmodule
